// ----- hw/rtl/pcnw_pkg.sv -----
// shared types and constants of the periodic cell neighbour walker
package pcnw_pkg;

	localparam int unsigned REACH = 1;
	localparam int unsigned SPAN  = 2 * REACH + 1;
	localparam int unsigned ID_W  = 23;
	localparam int unsigned CW    = 8;

	localparam logic [CW-1:0] COUNT_MIN = 8'd3;
	localparam logic [CW-1:0] COUNT_MAX = 8'd200;

	// which walk counter drives an axis
	localparam logic [1:0] SEL_I = 2'd0;
	localparam logic [1:0] SEL_J = 2'd1;
	localparam logic [1:0] SEL_K = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_COUNT_X = 2'd0;
	localparam logic [1:0] REG_COUNT_Y = 2'd1;
	localparam logic [1:0] REG_COUNT_Z = 2'd2;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef logic [CW-1:0] coord_t;
	typedef coord_t [2:0] triple_t;
	typedef logic [ID_W-1:0] cell_id_t;
	typedef logic [1:0] cnt_t;

	typedef struct packed {
		triple_t [2:0] vals;
		logic [2:0][1:0] sel;
		logic face;
		cell_id_t dest;
	} entry_t;

	typedef struct packed {
		logic valid;
		entry_t ent;
	} qbeat_t;

endpackage

// ----- hw/rtl/pcnw_front.sv -----
// front end: reduces coordinates, works out the wrapped offsets and the destination id
module pcnw_front (
	input  logic clk,
	input  logic arst_n,
	input  pcnw_pkg::triple_t counts,
	input  logic in_valid,
	output logic in_stall,
	input  logic func,
	input  logic [7:0] cell_x,
	input  logic [7:0] cell_y,
	input  logic [7:0] cell_z,
	input  logic [1:0] exit_axis,
	input  logic moving_up,
	output pcnw_pkg::qbeat_t push,
	input  logic full
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_WRAP = 3'd2;
	localparam logic [2:0] ST_MUL1 = 3'd3;
	localparam logic [2:0] ST_MUL2 = 3'd4;
	localparam logic [2:0] ST_PUSH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] bit_q;
	logic func_q;
	logic up_q;
	logic [1:0] ax_q;
	pcnw_pkg::triple_t raw_q;
	pcnw_pkg::triple_t rem_q;
	pcnw_pkg::triple_t rem_nx;
	pcnw_pkg::triple_t dc_q;
	pcnw_pkg::triple_t dc_c;
	logic [15:0] dt_q;
	pcnw_pkg::entry_t ent_q;
	pcnw_pkg::entry_t ent_c;
	logic [1:0] d1;
	logic accept;
	logic [15:0] prod1;
	logic [16:0] sum1;
	logic [23:0] prod2;
	logic [23:0] sum2;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && (state_q == ST_IDLE);

	// restoring remainder, one bit a cycle for each axis
	always_comb begin
		logic [8:0] trial;
		for (int a = 0; a < 3; a++) begin
			trial = {rem_q[a], raw_q[a][bit_q]};
			if (trial >= {1'b0, counts[a]}) begin
				rem_nx[a] = pcnw_pkg::coord_t'(trial - {1'b0, counts[a]});
			end else begin
				rem_nx[a] = trial[7:0];
			end
		end
	end

	// first axis after the exit axis in cyclic order
	always_comb begin
		unique case (ax_q)
			pcnw_pkg::AXIS_X: d1 = pcnw_pkg::AXIS_Y;
			pcnw_pkg::AXIS_Y: d1 = pcnw_pkg::AXIS_Z;
			default: d1 = pcnw_pkg::AXIS_X;
		endcase
	end

	always_comb begin
		pcnw_pkg::coord_t c, n, m1, p1, m2, p2;
		logic [8:0] p2w;
		ent_c = ent_q;
		ent_c.face = func_q;
		for (int a = 0; a < 3; a++) begin
			c = rem_q[a];
			n = counts[a];
			p1 = (c == n - 8'd1) ? 8'd0 : c + 8'd1;
			m1 = (c == 8'd0) ? n - 8'd1 : c - 8'd1;
			p2w = {1'b0, c} + 9'd2;
			p2 = (p2w >= {1'b0, n}) ? pcnw_pkg::coord_t'(p2w - {1'b0, n}) : p2w[7:0];
			m2 = (c < 8'd2) ? c + n - 8'd2 : c - 8'd2;
			ent_c.vals[a][0] = m1;
			ent_c.vals[a][1] = c;
			ent_c.vals[a][2] = p1;
			dc_c[a] = c;
			if (!func_q) begin
				ent_c.sel[a] = (a == 0) ? pcnw_pkg::SEL_I :
					(a == 1) ? pcnw_pkg::SEL_J : pcnw_pkg::SEL_K;
			end else if (2'(a) == ax_q) begin
				// face plane sits two steps out, held for the whole walk
				ent_c.sel[a] = pcnw_pkg::SEL_K;
				ent_c.vals[a][0] = up_q ? p2 : m2;
				ent_c.vals[a][1] = up_q ? p2 : m2;
				ent_c.vals[a][2] = up_q ? p2 : m2;
				dc_c[a] = up_q ? p1 : m1;
			end else if (2'(a) == d1) begin
				ent_c.sel[a] = pcnw_pkg::SEL_I;
			end else begin
				ent_c.sel[a] = pcnw_pkg::SEL_J;
			end
		end
	end

	assign prod1 = {8'b0, counts[1]} * {8'b0, dc_q[2]};
	assign sum1 = {1'b0, prod1} + {9'b0, dc_q[1]};
	assign prod2 = {16'b0, counts[0]} * {8'b0, dt_q};
	assign sum2 = prod2 + {16'b0, dc_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q <= 3'd7;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						bit_q <= 3'd7;
					end
				end
				ST_DIV: begin
					if (bit_q == 3'd0) begin
						state_q <= ST_WRAP;
					end
					bit_q <= bit_q - 3'd1;
				end
				ST_WRAP: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_PUSH;
				ST_PUSH: begin
					if (!full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			up_q <= moving_up;
			ax_q <= (exit_axis > pcnw_pkg::AXIS_Z) ? pcnw_pkg::AXIS_Z : exit_axis;
			raw_q[0] <= cell_x;
			raw_q[1] <= cell_y;
			raw_q[2] <= cell_z;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_nx;
		end
		if (state_q == ST_WRAP) begin
			ent_q <= ent_c;
			dc_q <= dc_c;
		end
		if (state_q == ST_MUL1) begin
			dt_q <= sum1[15:0];
		end
		if (state_q == ST_MUL2) begin
			ent_q.dest <= sum2[pcnw_pkg::ID_W-1:0];
		end
	end

	always_comb begin
		push.valid = (state_q == ST_PUSH);
		push.ent = ent_q;
	end

endmodule

// ----- hw/rtl/pcnw_queue.sv -----
// short queue of prepared walks between front and back
module pcnw_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  pcnw_pkg::qbeat_t push,
	output logic full,
	output pcnw_pkg::qbeat_t head,
	input  logic pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	pcnw_pkg::entry_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] fill_q;
	logic do_push;
	logic do_pop;

	assign full = (fill_q == CNT_FULL);
	assign do_push = push.valid && !full;
	assign do_pop = pop && (fill_q != '0);

	always_comb begin
		head.valid = (fill_q != '0);
		head.ent = slot_q[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push.ent;
		end
	end

endmodule

// ----- hw/rtl/pcnw_back.sv -----
// back end: walks the block or face and forms one cell id a cycle while the output is not held
module pcnw_back (
	input  logic clk,
	input  logic arst_n,
	input  pcnw_pkg::triple_t counts,
	input  pcnw_pkg::qbeat_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [22:0] neighbour_cell,
	output logic [22:0] destination_cell,
	output logic last
);

	localparam pcnw_pkg::cnt_t LAST_IDX = pcnw_pkg::cnt_t'(pcnw_pkg::SPAN - 1);

	pcnw_pkg::entry_t cur_q;
	logic active_q;
	pcnw_pkg::cnt_t i_q, j_q, k_q;
	logic adv;
	logic done;
	pcnw_pkg::triple_t pick;

	logic v_s1, last_s1;
	pcnw_pkg::triple_t p_s1;
	pcnw_pkg::cell_id_t dest_s1;

	logic v_s2, last_s2;
	pcnw_pkg::coord_t px_s2;
	logic [15:0] t_s2;
	pcnw_pkg::cell_id_t dest_s2;

	logic v_s3, last_s3;
	pcnw_pkg::cell_id_t id_s3;
	pcnw_pkg::cell_id_t dest_s3;

	logic [15:0] prod1;
	logic [16:0] sum1;
	logic [23:0] prod2;
	logic [23:0] sum2;

	// whole pipe moves unless the output beat is held
	assign adv = !(v_s3 && out_stall);
	assign done = (i_q == LAST_IDX) && (j_q == LAST_IDX) && (cur_q.face || (k_q == LAST_IDX));
	assign pop = adv && head.valid && (!active_q || done);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			unique case (cur_q.sel[a])
				pcnw_pkg::SEL_I: pick[a] = cur_q.vals[a][i_q];
				pcnw_pkg::SEL_J: pick[a] = cur_q.vals[a][j_q];
				pcnw_pkg::SEL_K: pick[a] = cur_q.vals[a][k_q];
				default: pick[a] = cur_q.vals[a][0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= active_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (pop) begin
				active_q <= 1'b1;
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end else if (active_q && done) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				if (i_q == LAST_IDX) begin
					i_q <= '0;
					if (j_q == LAST_IDX) begin
						j_q <= '0;
						k_q <= k_q + 2'd1;
					end else begin
						j_q <= j_q + 2'd1;
					end
				end else begin
					i_q <= i_q + 2'd1;
				end
			end
		end
	end

	assign prod1 = {8'b0, counts[1]} * {8'b0, p_s1[2]};
	assign sum1 = {1'b0, prod1} + {9'b0, p_s1[1]};
	assign prod2 = {16'b0, counts[0]} * {8'b0, t_s2};
	assign sum2 = prod2 + {16'b0, px_s2};

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.ent;
		end
		if (adv) begin
			p_s1 <= pick;
			dest_s1 <= cur_q.dest;
			last_s1 <= done;
			px_s2 <= p_s1[0];
			t_s2 <= sum1[15:0];
			dest_s2 <= dest_s1;
			last_s2 <= last_s1;
			id_s3 <= sum2[pcnw_pkg::ID_W-1:0];
			dest_s3 <= dest_s2;
			last_s3 <= last_s2;
		end
	end

	assign out_valid = v_s3;
	assign neighbour_cell = id_s3;
	assign destination_cell = dest_s3;
	assign last = last_s3;

endmodule

// ----- hw/rtl/periodic_cell_neighbour_walker.sv -----
// top level of the periodic cell neighbour walker
// Lists neighbour cell ids on a periodic 3D grid, one result beat per cycle
// while the output is not stalled. A neighbourhood query gives 27 beats and a
// crossing query gives 9 beats. The front end takes one item at a time and
// stalls its input until that item is pushed, working through the bit-serial
// remainder that folds each coordinate into range (8 steps) and the two
// multiply steps of the destination id. Prepared items wait in a short queue,
// so the next item is taken while the current walk is still emitting. Counts
// are clamped to 3..200 and are to be written only while the block is idle.
module periodic_cell_neighbour_walker #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [1:0] wr_index,
	input  logic [7:0] wr_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic func,
	input  logic [7:0] cell_x,
	input  logic [7:0] cell_y,
	input  logic [7:0] cell_z,
	input  logic [1:0] exit_axis,
	input  logic moving_up,
	output logic out_valid,
	input  logic out_stall,
	output logic [22:0] neighbour_cell,
	output logic [22:0] destination_cell,
	output logic last
);

	pcnw_pkg::triple_t count_q;
	pcnw_pkg::triple_t counts;
	pcnw_pkg::qbeat_t push;
	pcnw_pkg::qbeat_t head;
	logic full;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q[0] <= pcnw_pkg::COUNT_MIN;
			count_q[1] <= pcnw_pkg::COUNT_MIN;
			count_q[2] <= pcnw_pkg::COUNT_MIN;
		end else if (wr_en) begin
			unique case (wr_index)
				pcnw_pkg::REG_COUNT_X: count_q[0] <= wr_data;
				pcnw_pkg::REG_COUNT_Y: count_q[1] <= wr_data;
				pcnw_pkg::REG_COUNT_Z: count_q[2] <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (count_q[a] < pcnw_pkg::COUNT_MIN) begin
				counts[a] = pcnw_pkg::COUNT_MIN;
			end else if (count_q[a] > pcnw_pkg::COUNT_MAX) begin
				counts[a] = pcnw_pkg::COUNT_MAX;
			end else begin
				counts[a] = count_q[a];
			end
		end
	end

	pcnw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.counts    (counts),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.cell_z    (cell_z),
		.exit_axis (exit_axis),
		.moving_up (moving_up),
		.push      (push),
		.full      (full)
	);

	pcnw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.head   (head),
		.pop    (pop)
	);

	pcnw_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.counts           (counts),
		.head             (head),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.neighbour_cell   (neighbour_cell),
		.destination_cell (destination_cell),
		.last             (last)
	);

endmodule

// ----- hw/rtl/pcnw_checker.sv -----
// port checker for the periodic cell neighbour walker, bound to the top level
module pcnw_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic [22:0] neighbour_cell,
	input logic [22:0] destination_cell,
	input logic last
);

	localparam logic [22:0] ID_LIMIT = 23'd8000000;

	// a held beat keeps its payload
	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(neighbour_cell)
			&& $stable(destination_cell) && $stable(last))
		else $error("output beat changed while stalled");

	// a walk runs without gaps until its last beat
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a walk");

	a_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (neighbour_cell < ID_LIMIT) && (destination_cell < ID_LIMIT))
		else $error("cell id beyond largest grid");

endmodule

bind periodic_cell_neighbour_walker pcnw_checker u_pcnw_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.neighbour_cell   (neighbour_cell),
	.destination_cell (destination_cell),
	.last             (last)
);
